[src/assert_macros.svh]
// -----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the allocator modules.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define FFPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// condition must never be seen out of reset
`define FFPA_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define FFPA_ASSERT(label, prop, msg)
`define FFPA_NEVER(label, cond, msg)
`endif

`endif

[src/ffpa_pkg.sv]
// -----------------------------------------------------------------------------
// ffpa_pkg
// Codes and controller/datapath interface types of the first-fit allocator.
// -----------------------------------------------------------------------------
package ffpa_pkg;

    localparam logic       OP_ALLOC = 1'b0;
    localparam logic       OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NOMEM   = 2'd2;

    localparam logic       CFG_POOL_BYTES = 1'b0;
    localparam logic       CFG_ALIGN_LOG2 = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_GETH = 8'b0000_0010,
        S_CHK  = 8'b0000_0100,
        S_GETN = 8'b0000_1000,
        S_DEC  = 8'b0001_0000,
        S_WRH  = 8'b0010_0000,
        S_RESP = 8'b0100_0000,
        S_SPARE = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic accept;
        logic init;
        logic load_h;
        logic rd_next;
        logic merge;
        logic step;
        logic take;
        logic free_mark;
        logic wr_h;
        logic res_inv;
        logic res_oom;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic init_pend;
        logic is_free;
        logic bad;
        logic walk_more;
        logic n_free;
        logic fit;
        logic has_next;
        logic at_target;
    } t_stat;

endpackage

[src/ffpa_ram.sv]
// -----------------------------------------------------------------------------
// ffpa_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module ffpa_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/ffpa_dp.sv]
// -----------------------------------------------------------------------------
// ffpa_dp
// Allocator datapath: configuration, header store, walk registers, result.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffpa_dp import ffpa_pkg::*; #(
    parameter int POOL_BYTES   = 4096,
    parameter int HEADER_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_operation,
    input  logic [12:0] i_request_size,
    input  logic [11:0] i_release_offset,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic [1:0]  o_status,
    output logic [11:0] o_payload_offset
);

    localparam int OFF_W = $clog2(POOL_BYTES);
    localparam int OW    = (OFF_W > 12) ? OFF_W : 12;
    localparam int SW    = OW + 2;
    localparam int PW    = (OFF_W + 2 > 14) ? OFF_W + 2 : 14;
    localparam int DEPTH = POOL_BYTES / 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int HW    = 2 * OW + 2;

    logic [12:0]   r_pool_bytes;
    logic [2:0]    r_align_log2;
    logic          r_init_pend;
    logic          r_op;
    logic [SW-1:0] r_asz;
    logic [OW-1:0] r_target;
    logic [OW-1:0] r_cur;
    logic [OW-1:0] r_size;
    logic [OW-1:0] r_next;
    logic          r_hnext;
    logic          r_alloc;
    logic [1:0]    r_res_status;
    logic [11:0]   r_res_payload;
    logic [1:0]    r_ostatus;
    logic [11:0]   r_opayload;

    logic [HW-1:0] w_rdata;
    logic [OW-1:0] w_nsize;
    logic [OW-1:0] w_nnext;
    logic          w_nhnext;
    logic          w_nalloc;
    logic [PW-1:0] w_pool;
    logic [PW-1:0] w_pclamp;
    logic [OW-1:0] w_init_size;
    logic [2:0]    w_lg;
    logic [SW-1:0] w_aone;
    logic [SW-1:0] w_asz;
    logic          w_bad;
    logic [SW-1:0] w_diff;
    logic          w_fit;
    logic          w_split;
    logic [OW-1:0] w_nb_off;
    logic [OW-1:0] w_nb_size;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [HW-1:0] w_wdata;
    logic [AW-1:0] w_raddr;

    assign w_nsize  = w_rdata[OW-1:0];
    assign w_nnext  = w_rdata[2*OW-1:OW];
    assign w_nhnext = w_rdata[2*OW];
    assign w_nalloc = w_rdata[2*OW+1];

    // first block covers the clamped pool less one header
    assign w_pool      = PW'(r_pool_bytes);
    assign w_pclamp    = (w_pool > PW'(POOL_BYTES)) ? PW'(POOL_BYTES) : w_pool;
    assign w_init_size = (w_pclamp > PW'(HEADER_BYTES))
                       ? OW'(w_pclamp - PW'(HEADER_BYTES)) : '0;

    assign w_lg   = (r_align_log2 == 3'd0) ? 3'd1
                  : (r_align_log2 > 3'd6)  ? 3'd6 : r_align_log2;
    assign w_aone = SW'(1) << w_lg;
    assign w_asz  = (SW'(i_request_size) + w_aone - SW'(1)) & ~(w_aone - SW'(1));

    assign w_bad = (i_operation == OP_ALLOC) ? (i_request_size == 13'd0)
                 : ((i_release_offset == 12'd0) ||
                    (OW'(i_release_offset) < OW'(HEADER_BYTES)));

    assign w_diff    = SW'(r_size) - r_asz;
    assign w_fit     = !r_alloc && (SW'(r_size) >= r_asz);
    assign w_split   = w_diff > SW'(HEADER_BYTES);
    assign w_nb_off  = r_cur + OW'(r_asz) + OW'(HEADER_BYTES);
    assign w_nb_size = OW'(w_diff - SW'(HEADER_BYTES));

    // one write a cycle: init, split-off block, or current header
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cur[OFF_W-1:1];
        w_wdata = {r_alloc, r_hnext, r_next, r_size};
        if (i_cmd.init) begin
            w_we    = 1'b1;
            w_waddr = '0;
            w_wdata = {1'b0, 1'b0, {OW{1'b0}}, w_init_size};
        end else if (i_cmd.take && w_split) begin
            w_we    = 1'b1;
            w_waddr = w_nb_off[OFF_W-1:1];
            w_wdata = {1'b0, r_hnext, r_next, w_nb_size};
        end else if (i_cmd.wr_h || i_cmd.step) begin
            w_we = 1'b1;
        end
    end

    assign w_raddr = i_cmd.accept ? '0 : r_next[OFF_W-1:1];

    ffpa_ram #(
        .WIDTH (HW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_bytes <= 13'd4096;
            r_align_log2 <= 3'd2;
            r_init_pend  <= 1'b1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_POOL_BYTES) begin
                r_pool_bytes <= i_cfg_data;
            end else begin
                r_align_log2 <= i_cfg_data[2:0];
            end
            r_init_pend <= 1'b1;
        end else if (i_cmd.init) begin
            r_init_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_operation;
            r_asz    <= w_asz;
            r_target <= OW'(i_release_offset) - OW'(HEADER_BYTES);
            r_cur    <= '0;
            if (w_bad) begin
                r_res_status  <= ST_INVALID;
                r_res_payload <= '0;
            end
        end
        if (i_cmd.load_h) begin
            r_size  <= w_nsize;
            r_next  <= w_nnext;
            r_hnext <= w_nhnext;
            r_alloc <= w_nalloc;
        end
        // absorb a free neighbour
        if (i_cmd.merge && !w_nalloc) begin
            r_size  <= r_size + w_nsize + OW'(HEADER_BYTES);
            r_next  <= w_nnext;
            r_hnext <= w_nhnext;
        end
        if (i_cmd.step) begin
            r_cur <= r_next;
        end
        if (i_cmd.take) begin
            r_alloc       <= 1'b1;
            r_res_status  <= ST_OK;
            r_res_payload <= 12'(r_cur + OW'(HEADER_BYTES));
            if (w_split) begin
                r_size  <= OW'(r_asz);
                r_next  <= w_nb_off;
                r_hnext <= 1'b1;
            end
        end
        if (i_cmd.free_mark) begin
            r_alloc       <= 1'b0;
            r_res_status  <= ST_OK;
            r_res_payload <= '0;
        end
        if (i_cmd.res_inv) begin
            r_res_status  <= ST_INVALID;
            r_res_payload <= '0;
        end
        if (i_cmd.res_oom) begin
            r_res_status  <= ST_NOMEM;
            r_res_payload <= '0;
        end
        if (i_cmd.load_out) begin
            r_ostatus  <= r_res_status;
            r_opayload <= r_res_payload;
        end
    end

    assign o_stat.init_pend = r_init_pend;
    assign o_stat.is_free   = (r_op == OP_FREE);
    assign o_stat.bad       = w_bad;
    assign o_stat.walk_more = !r_alloc && r_hnext;
    assign o_stat.n_free    = !w_nalloc;
    assign o_stat.fit       = w_fit;
    assign o_stat.has_next  = r_hnext;
    assign o_stat.at_target = (r_cur == r_target);

    assign o_status         = r_ostatus;
    assign o_payload_offset = r_opayload;

    // chain offsets rise strictly, so a walk step never reads the header it writes
    `FFPA_ASSERT(a_step_forward, i_cmd.step |-> (r_next > r_cur), "walk step goes backwards")
    `FFPA_NEVER(a_split_self, i_cmd.take && w_split && (w_nb_off[OFF_W-1:1] == r_cur[OFF_W-1:1]), "split block overlays its own header")

endmodule

[src/ffpa_ctrl.sv]
// -----------------------------------------------------------------------------
// ffpa_ctrl
// Allocator controller: sequences header reads, merges, splits and writes.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffpa_ctrl import ffpa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        o_ready  = 1'b0;
        n_ovalid = r_ovalid && !i_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_stat.init_pend) begin
                    o_cmd.init = 1'b1;
                end else begin
                    o_ready = 1'b1;
                    if (i_valid) begin
                        o_cmd.accept = 1'b1;
                        n_state      = i_stat.bad ? S_RESP : S_GETH;
                    end
                end
            end
            S_GETH: begin
                o_cmd.load_h = 1'b1;
                n_state      = S_CHK;
            end
            S_CHK: begin
                if (!i_stat.is_free) begin
                    if (i_stat.walk_more) begin
                        o_cmd.rd_next = 1'b1;
                        n_state       = S_GETN;
                    end else begin
                        n_state = S_DEC;
                    end
                end else if (i_stat.at_target) begin
                    o_cmd.free_mark = 1'b1;
                    if (i_stat.has_next) begin
                        o_cmd.rd_next = 1'b1;
                        n_state       = S_GETN;
                    end else begin
                        n_state = S_WRH;
                    end
                end else if (i_stat.has_next) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_GETH;
                end else begin
                    o_cmd.res_inv = 1'b1;
                    n_state       = S_RESP;
                end
            end
            S_GETN: begin
                o_cmd.merge = 1'b1;
                if (i_stat.is_free) begin
                    n_state = S_WRH;
                end else if (i_stat.n_free) begin
                    n_state = S_CHK;
                end else begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.fit) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_WRH;
                end else if (i_stat.has_next) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_GETH;
                end else begin
                    // keep any merges made on the last block
                    o_cmd.wr_h    = 1'b1;
                    o_cmd.res_oom = 1'b1;
                    n_state       = S_RESP;
                end
            end
            S_WRH: begin
                o_cmd.wr_h = 1'b1;
                n_state    = S_RESP;
            end
            S_RESP: begin
                if (!r_ovalid || i_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid = r_ovalid;

    `FFPA_ASSERT(a_accept_leaves_idle, (i_valid && o_ready) |=> (r_state != S_IDLE), "accepted transaction left controller idle")
    `FFPA_ASSERT(a_resp_waits, (r_state == S_RESP && r_ovalid && !i_ready) |=> (r_state == S_RESP && r_ovalid), "result overwrote a pending transaction")
    `FFPA_NEVER(a_ready_busy, o_ready && (r_state != S_IDLE), "ready raised while busy")

endmodule

[src/first_fit_pool_allocator_unit.sv]
// Sequence: an invalid request goes from idle straight to the response state; a free
//   reads and checks each chain block in turn, and an allocate also merges free neighbours.
// One transaction at a time, set by the walk of the header store.
// The next transaction is taken while a finished result still waits at the output.
// Reset (synchronous, active low) clears control and restores the registers; the
//   first header is written in the cycle after reset, and once idle after any register write.
// -----------------------------------------------------------------------------
// first_fit_pool_allocator_unit
// First-fit pool allocator with coalescing and block splitting.
// -----------------------------------------------------------------------------
module first_fit_pool_allocator_unit import ffpa_pkg::*; #(
    parameter int POOL_BYTES   = 4096,
    parameter int HEADER_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [12:0] i_request_size,
    input  logic [11:0] i_release_offset,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [11:0] o_payload_offset
);

    t_cmd  w_cmd;
    t_stat w_stat;

    ffpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    ffpa_dp #(
        .POOL_BYTES   (POOL_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_operation      (i_operation),
        .i_request_size   (i_request_size),
        .i_release_offset (i_release_offset),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_status         (o_status),
        .o_payload_offset (o_payload_offset)
    );

endmodule

[sim/first_fit_pool_allocator_unit_test.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// first_fit_pool_allocator_unit_test
// Self-checking bench: drives allocate and free transactions with random gaps
// and output stalls, predicts each result with a behavioural model of the
// header chain and compares status and payload offset in order.
// -----------------------------------------------------------------------------
module first_fit_pool_allocator_unit_test;
    import ffpa_pkg::*;

    localparam int POOL_MAX  = 4096;
    localparam int HDR       = 8;
    localparam int DEPTH     = POOL_MAX / 2;
    localparam int WALK_MAX  = DEPTH + 1;
    localparam int CYCLE_CAP = 20000000;

    typedef struct {
        int unsigned sz;
        int unsigned nxt;
        bit          has_nxt;
        bit          used;
    } hdr_t;

    typedef struct {
        logic [1:0]  status;
        logic [11:0] offset;
    } result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [12:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_operation = OP_ALLOC;
    logic [12:0] i_request_size = '0;
    logic [11:0] i_release_offset = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [11:0] o_payload_offset;

    first_fit_pool_allocator_unit dut (.*);

    always #1 i_clk = ~i_clk;

    hdr_t        chain [DEPTH];
    int unsigned cur_pool;
    int unsigned cur_align;
    result_t     expected_results[$];
    int unsigned live_offsets[$];
    int          errors = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_ok = 0;
    int          n_oom = 0;
    int          n_inv = 0;
    longint      cycles = 0;
    bit          hold_off = 1'b0;
    int          hold_cycles = 0;

    function automatic int unsigned idx(input int unsigned off);
        return (off >> 1) % DEPTH;
    endfunction

    function automatic void pool_reset();
        int unsigned p;
        p = (cur_pool > POOL_MAX) ? POOL_MAX : cur_pool;
        foreach (chain[k]) chain[k] = '{0, 0, 1'b0, 1'b0};
        chain[0].sz = (p > HDR) ? p - HDR : 0;
        live_offsets.delete();
    endfunction

    function automatic result_t predict_alloc(input int unsigned req);
        result_t r;
        int unsigned lg, a, asz, cur, nb;
        r = '{ST_OK, 12'd0};
        if (req == 0) begin
            r.status = ST_INVALID;
            return r;
        end
        lg = (cur_align < 1) ? 1 : (cur_align > 6) ? 6 : cur_align;
        a = 1 << lg;
        asz = (req + a - 1) & ~(a - 1);
        cur = 0;
        for (int s = 0; s < WALK_MAX; s++) begin
            while (!chain[idx(cur)].used && chain[idx(cur)].has_nxt &&
                   !chain[idx(chain[idx(cur)].nxt)].used) begin
                nb = idx(chain[idx(cur)].nxt);
                chain[idx(cur)].sz += chain[nb].sz + HDR;
                chain[idx(cur)].has_nxt = chain[nb].has_nxt;
                chain[idx(cur)].nxt = chain[nb].nxt;
            end
            if (!chain[idx(cur)].used && chain[idx(cur)].sz >= asz) begin
                if (chain[idx(cur)].sz - asz > HDR) begin
                    nb = cur + asz + HDR;
                    chain[idx(nb)].sz = chain[idx(cur)].sz - asz - HDR;
                    chain[idx(nb)].nxt = chain[idx(cur)].nxt;
                    chain[idx(nb)].has_nxt = chain[idx(cur)].has_nxt;
                    chain[idx(nb)].used = 1'b0;
                    chain[idx(cur)].sz = asz;
                    chain[idx(cur)].nxt = nb;
                    chain[idx(cur)].has_nxt = 1'b1;
                end
                chain[idx(cur)].used = 1'b1;
                r.offset = 12'(cur + HDR);
                return r;
            end
            if (!chain[idx(cur)].has_nxt) break;
            cur = chain[idx(cur)].nxt;
        end
        r.status = ST_NOMEM;
        return r;
    endfunction

    function automatic result_t predict_free(input int unsigned off);
        result_t r;
        int unsigned tgt, cur, nb;
        bit found;
        r = '{ST_INVALID, 12'd0};
        found = 1'b0;
        if (off < HDR) return r;
        tgt = off - HDR;
        cur = 0;
        for (int s = 0; s < WALK_MAX; s++) begin
            if (cur == tgt) begin
                found = 1'b1;
                break;
            end
            if (!chain[idx(cur)].has_nxt) break;
            cur = chain[idx(cur)].nxt;
        end
        if (!found) return r;
        chain[idx(tgt)].used = 1'b0;
        if (chain[idx(tgt)].has_nxt && !chain[idx(chain[idx(tgt)].nxt)].used) begin
            nb = idx(chain[idx(tgt)].nxt);
            chain[idx(tgt)].sz += chain[nb].sz + HDR;
            chain[idx(tgt)].has_nxt = chain[nb].has_nxt;
            chain[idx(tgt)].nxt = chain[nb].nxt;
        end
        r.status = ST_OK;
        return r;
    endfunction

    // sender gap drawn per transaction; zero gap in bursts
    // valid holds across back-to-back transactions; a gap or drain drops it
    task automatic send_request(input logic op, input int unsigned req,
                                input int unsigned off, input bit no_gap = 0);
        result_t r;
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_request_size <= 13'(req);
        i_release_offset <= 12'(off);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (op == OP_ALLOC) begin
            r = predict_alloc(req);
            if (r.status == ST_OK) live_offsets.push_back(r.offset);
        end else begin
            r = predict_free(off);
        end
        expected_results.push_back(r);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic index, input int unsigned value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= 13'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == CFG_POOL_BYTES) cur_pool = value & 13'h1fff;
        else cur_align = value & 3'h7;
        pool_reset();
        repeat (4) @(negedge i_clk);
    endtask

    // pick a free target: mostly a live block, sometimes garbage
    task automatic random_free();
        int unsigned off;
        int k;
        if (live_offsets.size() != 0 && $urandom_range(0, 9) < 8) begin
            k = $urandom_range(0, live_offsets.size() - 1);
            off = live_offsets[k];
            if ($urandom_range(0, 4) != 0) live_offsets.delete(k);
        end else begin
            off = $urandom_range(0, 4095);
        end
        send_request(OP_FREE, 0, off);
    endtask

    task automatic random_alloc();
        int unsigned req;
        case ($urandom_range(0, 9))
            0: req = $urandom_range(0, 8191);
            1: req = $urandom_range(0, 4096);
            default: req = $urandom_range(1, 128);
        endcase
        send_request(OP_ALLOC, req, $urandom_range(0, 4095));
    endtask

    task automatic test_directed();
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_FREE, 0, 0);
        send_request(OP_FREE, 0, 4);
        send_request(OP_FREE, 0, 12'hfff);
        send_request(OP_ALLOC, 1, 0);
        send_request(OP_ALLOC, 13, 0);
        send_request(OP_ALLOC, 8191, 12'hfff);
        send_request(OP_ALLOC, 4096, 0);
        send_request(OP_FREE, 0, 8);
        send_request(OP_FREE, 0, 8);
        send_request(OP_FREE, 0, 20);
        send_request(OP_ALLOC, 4080, 0);
        send_request(OP_ALLOC, 4, 0);
        send_request(OP_FREE, 0, 8);
        send_request(OP_ALLOC, 4088, 0);
        send_request(OP_FREE, 0, 8);
        send_request(OP_ALLOC, 4089, 0);
        send_request(OP_ALLOC, 5461, 12'haaa);
        send_request(OP_ALLOC, 2730, 12'h555);
    endtask

    task automatic test_random(input int count);
        repeat (count) begin
            if ($urandom_range(0, 99) < 55) random_alloc();
            else random_free();
        end
    endtask

    task automatic test_config_sweep();
        write_reg(CFG_ALIGN_LOG2, 0);
        test_random(60);
        write_reg(CFG_ALIGN_LOG2, 7);
        test_random(60);
        write_reg(CFG_ALIGN_LOG2, 6);
        write_reg(CFG_POOL_BYTES, 16);
        send_request(OP_ALLOC, 1, 0);
        send_request(OP_ALLOC, 9, 0);
        test_random(20);
        write_reg(CFG_POOL_BYTES, 4);
        send_request(OP_ALLOC, 1, 0);
        test_random(10);
        write_reg(CFG_POOL_BYTES, 13'h1fff);
        write_reg(CFG_ALIGN_LOG2, 1);
        test_random(120);
        write_reg(CFG_POOL_BYTES, 300);
        write_reg(CFG_ALIGN_LOG2, 3);
        test_random(150);
        write_reg(CFG_POOL_BYTES, 4096);
        write_reg(CFG_ALIGN_LOG2, 2);
    endtask

    // stall the output for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        hold_cycles = 400;
        hold_off = 1'b1;
        repeat (6) send_request(OP_ALLOC, $urandom_range(1, 64), 0, 1);
        drain();
        test_random(30);
    endtask

    initial begin
        cur_pool = 4096;
        cur_align = 2;
        pool_reset();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(negedge i_clk);
        test_directed();
        drain();
        test_random(400);
        test_backpressure();
        test_config_sweep();
        test_random(100);
        drain();
        $display("Covered %0d transactions: %0d ok, %0d invalid, %0d out of memory",
                 n_checked, n_ok, n_inv, n_oom);
        $display("Swept pool size and alignment over their extremes with output stalls.");
        if (errors == 0) begin
            $display("first_fit_pool_allocator_unit verification clean");
        end else begin
            $display("first_fit_pool_allocator_unit verification failed");
        end
        $finish;
    end

    // receiver stall per result, plus the long hold-off
    initial begin
        int gap;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (hold_cycles) @(negedge i_clk);
                hold_off = 1'b0;
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                if (gap != 0) begin
                    @(negedge i_clk);
                    i_ready <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        result_t e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("first_fit_pool_allocator_unit verification failed");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d offset=%0d",
                         $time, o_status, o_payload_offset);
                errors++;
            end else begin
                e = expected_results.pop_front();
                n_checked++;
                if (e.status == ST_OK) n_ok++;
                else if (e.status == ST_NOMEM) n_oom++;
                else n_inv++;
                if (o_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, o_status);
                    errors++;
                end
                if (o_payload_offset !== e.offset) begin
                    $display("%0t: payload_offset expected %0d actual %0d",
                             $time, e.offset, o_payload_offset);
                    errors++;
                end
            end
        end
    end

endmodule
